// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/dpd_pkg.sv =====
`default_nettype none

package dpd_pkg;

  localparam int MAG_BITS = 29;
  localparam int INV_BITS = 24;
  localparam int PROD_BITS = MAG_BITS + INV_BITS;
  localparam int M_BITS = 40;
  localparam int HALF_BITS = 20;
  localparam int PART_BITS = 49;
  localparam int SUM_BITS = 69;
  localparam int FRAC_BITS = 24;
  localparam int Q_BITS = SUM_BITS - FRAC_BITS;
  localparam int XY_BITS = 33;
  localparam int WIDTH_REG_BITS = 13;
  localparam int FRAME_REG_BITS = 25;
  localparam int ROW_BITS = 24;
  localparam int PIX_BITS = 24;
  localparam int CFG_DATA_BITS = 25;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [Q_BITS-1:0] XY_LIMIT = 45'd4294836225;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_FX = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_FY = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REVERSE = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR_EN = 3'd7;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL_M,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SUM,
    OP_SAT
  } dp_op_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
    logic   axis;
    logic   load;
  } ctl_cmd_t;

endpackage

`default_nettype wire

// ===== src/depth_pixel_deprojection.sv =====
// pixels are taken one at a time: a new pixel is accepted only after the last one has
// been loaded into the output register; each axis runs three products on the shared
// 29x24 multiplier, then a sum and a saturation
// the result register holds one finished point, so the next pixel computes while it waits
// reset (rst, synchronous, active high) clears counters, state and output valid,
// and sets registers to their defaults
`default_nettype none

`include "assert_macros.svh"

module depth_pixel_deprojection #(
  parameter int COLUMN_BITS = 12
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [24:0]   cfg_data,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // depth, color byte 0, color byte 1, color byte 2
  input  wire logic [39:0]   s_tdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // point_x_q4, point_y_q4, point_z_mm, color_word, zero fill
  output logic [111:0]       m_tdata,
  // frame_end
  output logic               m_tlast
);

  dpd_pkg::ctl_cmd_t cmd;
  logic              out_free;

  dpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .out_free (out_free),
    .cmd      (cmd)
  );

  dpd_datapath #(
    .COLUMN_BITS (COLUMN_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_IMPL(a_load_into_free_slot, clk, rst, cmd.load, !m_tvalid || m_tready)
  `ASSERT_IMPL(a_valid_from_load, clk, rst, $rose(m_tvalid), $past(cmd.load))

endmodule

`default_nettype wire

// ===== src/dpd_ctrl.sv =====
`default_nettype none

module dpd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic              out_free,
  output dpd_pkg::ctl_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_M,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_SAT,
    S_LOAD
  } state_t;

  state_t state;
  logic   axis;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_MUL_M;
            axis <= 1'b0;
          end
        end
        S_MUL_M: state <= S_MUL_LO;
        S_MUL_LO: state <= S_MUL_HI;
        S_MUL_HI: state <= S_SUM;
        S_SUM: state <= S_SAT;
        S_SAT: begin
          if (axis) begin
            state <= S_LOAD;
          end else begin
            state <= S_MUL_M;
            axis <= 1'b1;
          end
        end
        S_LOAD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd.accept = (state == S_IDLE) && s_tvalid;
    cmd.axis = axis;
    cmd.load = (state == S_LOAD) && out_free;
    unique case (state)
      S_MUL_M: cmd.op = dpd_pkg::OP_MUL_M;
      S_MUL_LO: cmd.op = dpd_pkg::OP_MUL_LO;
      S_MUL_HI: cmd.op = dpd_pkg::OP_MUL_HI;
      S_SUM: cmd.op = dpd_pkg::OP_SUM;
      S_SAT: cmd.op = dpd_pkg::OP_SAT;
      default: cmd.op = dpd_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/dpd_datapath.sv =====
`default_nettype none

module dpd_datapath #(
  parameter int COLUMN_BITS = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [dpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [dpd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire logic [39:0]                         s_tdata,
  input  wire dpd_pkg::ctl_cmd_t                   cmd,
  output logic                                     out_free,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [111:0]                             m_tdata,
  output logic                                     m_tlast
);

  localparam int CMP_BITS = (COLUMN_BITS + 1 > dpd_pkg::WIDTH_REG_BITS) ?
                            COLUMN_BITS + 1 : dpd_pkg::WIDTH_REG_BITS;

  // configuration
  logic [15:0]                          center_x;
  logic [15:0]                          center_y;
  logic [dpd_pkg::INV_BITS-1:0]         inv_fx;
  logic [dpd_pkg::INV_BITS-1:0]         inv_fy;
  logic [dpd_pkg::WIDTH_REG_BITS-1:0]   image_width;
  logic [dpd_pkg::FRAME_REG_BITS-1:0]   frame_pixels;
  logic                                 reverse_order;
  logic                                 color_en;

  // position counters
  logic [COLUMN_BITS-1:0]               col;
  logic [dpd_pkg::ROW_BITS-1:0]         row;
  logic [dpd_pkg::PIX_BITS-1:0]         pix;

  // current item
  logic [15:0]                          depth_r;
  logic [23:0]                          color_r;
  logic                                 last_r;
  logic [dpd_pkg::MAG_BITS-1:0]         mag_x;
  logic [dpd_pkg::MAG_BITS-1:0]         mag_y;
  logic                                 neg_x;
  logic                                 neg_y;

  // arithmetic pipeline registers
  logic [dpd_pkg::M_BITS-1:0]           m_r;
  logic [dpd_pkg::PART_BITS-1:0]        plo_r;
  logic [dpd_pkg::PART_BITS-1:0]        phi_r;
  logic [dpd_pkg::Q_BITS-1:0]           q_r;
  logic [dpd_pkg::XY_BITS-1:0]          res_x;
  logic [dpd_pkg::XY_BITS-1:0]          res_y;

  // output register
  logic [dpd_pkg::XY_BITS-1:0]          x_o;
  logic [dpd_pkg::XY_BITS-1:0]          y_o;
  logic [15:0]                          z_o;
  logic [23:0]                          color_o;

  logic [CMP_BITS-1:0]                  col_inc;
  logic                                 col_wrap;
  logic [dpd_pkg::FRAME_REG_BITS-1:0]   pix_inc;
  logic                                 frame_last;
  logic [dpd_pkg::MAG_BITS-1:0]         ax;
  logic [dpd_pkg::MAG_BITS-1:0]         ay;
  logic [dpd_pkg::MAG_BITS-1:0]         cxe;
  logic [dpd_pkg::MAG_BITS-1:0]         cye;
  logic                                 neg_x_next;
  logic                                 neg_y_next;
  logic [dpd_pkg::MAG_BITS-1:0]         mag_x_next;
  logic [dpd_pkg::MAG_BITS-1:0]         mag_y_next;
  logic [23:0]                          color_next;

  logic [dpd_pkg::MAG_BITS-1:0]         mul_a;
  logic [dpd_pkg::INV_BITS-1:0]         mul_b;
  logic [dpd_pkg::PROD_BITS-1:0]        product;
  logic                                 neg_sel;
  logic [dpd_pkg::SUM_BITS-1:0]         full_sum;
  logic [dpd_pkg::Q_BITS-1:0]           q_next;
  logic [dpd_pkg::XY_BITS-1:0]          sat_mag;
  logic [dpd_pkg::XY_BITS-1:0]          sat_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      inv_fx <= '0;
      inv_fy <= '0;
      image_width <= 13'd640;
      frame_pixels <= 25'd307200;
      reverse_order <= 1'b0;
      color_en <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpd_pkg::REG_CENTER_X: center_x <= cfg_data[15:0];
        dpd_pkg::REG_CENTER_Y: center_y <= cfg_data[15:0];
        dpd_pkg::REG_INV_FX: inv_fx <= cfg_data[dpd_pkg::INV_BITS-1:0];
        dpd_pkg::REG_INV_FY: inv_fy <= cfg_data[dpd_pkg::INV_BITS-1:0];
        dpd_pkg::REG_WIDTH: image_width <= cfg_data[dpd_pkg::WIDTH_REG_BITS-1:0];
        dpd_pkg::REG_FRAME: frame_pixels <= cfg_data;
        dpd_pkg::REG_REVERSE: reverse_order <= cfg_data[0];
        dpd_pkg::REG_COLOR_EN: color_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // wrap tests; an all-ones counter also covers widths above the counter range
  always_comb begin
    col_inc = CMP_BITS'(col) + CMP_BITS'(1);
    col_wrap = (col_inc >= CMP_BITS'(image_width)) || (&col);
    pix_inc = dpd_pkg::FRAME_REG_BITS'(pix) + dpd_pkg::FRAME_REG_BITS'(1);
    frame_last = (pix_inc >= frame_pixels) || (&pix);
  end

  always_comb begin
    ax = dpd_pkg::MAG_BITS'({col, 4'b0000});
    ay = dpd_pkg::MAG_BITS'({row, 4'b0000});
    cxe = dpd_pkg::MAG_BITS'(center_x);
    cye = dpd_pkg::MAG_BITS'(center_y);
    neg_x_next = cxe > ax;
    neg_y_next = cye > ay;
    mag_x_next = neg_x_next ? cxe - ax : ax - cxe;
    mag_y_next = neg_y_next ? cye - ay : ay - cye;
    if (!color_en) begin
      color_next = '0;
    end else if (reverse_order) begin
      color_next = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
    end else begin
      color_next = s_tdata[39:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      pix <= '0;
    end else if (cmd.accept) begin
      if (frame_last) begin
        col <= '0;
        row <= '0;
        pix <= '0;
      end else begin
        pix <= pix + dpd_pkg::PIX_BITS'(1);
        if (col_wrap) begin
          col <= '0;
          row <= row + dpd_pkg::ROW_BITS'(1);
        end else begin
          col <= col + COLUMN_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      depth_r <= s_tdata[15:0];
      color_r <= color_next;
      last_r <= frame_last;
      mag_x <= mag_x_next;
      mag_y <= mag_y_next;
      neg_x <= neg_x_next;
      neg_y <= neg_y_next;
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = cmd.axis ? mag_y : mag_x;
    mul_b = '0;
    case (cmd.op)
      dpd_pkg::OP_MUL_M: begin
        mul_a = dpd_pkg::MAG_BITS'(depth_r);
        mul_b = cmd.axis ? inv_fy : inv_fx;
      end
      dpd_pkg::OP_MUL_LO: mul_b = dpd_pkg::INV_BITS'(m_r[dpd_pkg::HALF_BITS-1:0]);
      dpd_pkg::OP_MUL_HI: mul_b = dpd_pkg::INV_BITS'(m_r[dpd_pkg::M_BITS-1:dpd_pkg::HALF_BITS]);
      default: mul_b = '0;
    endcase
  end

  assign product = dpd_pkg::PROD_BITS'(mul_a) * dpd_pkg::PROD_BITS'(mul_b);

  // floor for negative offsets means rounding the magnitude up
  always_comb begin
    neg_sel = cmd.axis ? neg_y : neg_x;
    full_sum = {phi_r, {dpd_pkg::HALF_BITS{1'b0}}} + dpd_pkg::SUM_BITS'(plo_r);
    q_next = full_sum[dpd_pkg::SUM_BITS-1:dpd_pkg::FRAC_BITS] +
             dpd_pkg::Q_BITS'(neg_sel && (|full_sum[dpd_pkg::FRAC_BITS-1:0]));
    sat_mag = (q_r > dpd_pkg::XY_LIMIT) ? dpd_pkg::XY_LIMIT[dpd_pkg::XY_BITS-1:0] :
                                           q_r[dpd_pkg::XY_BITS-1:0];
    sat_val = neg_sel ? (~sat_mag + dpd_pkg::XY_BITS'(1)) : sat_mag;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      dpd_pkg::OP_MUL_M: m_r <= product[dpd_pkg::M_BITS-1:0];
      dpd_pkg::OP_MUL_LO: plo_r <= product[dpd_pkg::PART_BITS-1:0];
      dpd_pkg::OP_MUL_HI: phi_r <= product[dpd_pkg::PART_BITS-1:0];
      dpd_pkg::OP_SUM: q_r <= q_next;
      dpd_pkg::OP_SAT: begin
        if (cmd.axis) begin
          res_y <= sat_val;
        end else begin
          res_x <= sat_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_o <= res_x;
      y_o <= res_y;
      z_o <= depth_r;
      color_o <= color_r;
      m_tlast <= last_r;
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign m_tdata = {6'b000000, color_o, z_o, y_o, x_o};

endmodule

`default_nettype wire

// ===== sim/depth_pixel_deprojection_checker.sv =====
`default_nettype none

module depth_pixel_deprojection_checker #(
  parameter int COLUMN_BITS = 12
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [24:0]  cfg_data,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  // depth, color byte 0, color byte 1, color byte 2
  input  wire logic [39:0]  s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  // point_x_q4, point_y_q4, point_z_mm, color_word, zero fill
  input  wire logic [111:0] m_tdata,
  // frame_end
  input  wire logic         m_tlast,
  output int                mismatch_count,
  output int                points_in_flight,
  output int                points_checked,
  output int                frames_closed
);

  typedef struct packed {
    logic [32:0] x;
    logic [32:0] y;
    logic [15:0] z;
    logic [23:0] color;
    logic [5:0]  pad;
    logic        last;
  } point_t;

  point_t      expected_points[$];
  logic [15:0] center_x, center_y;
  logic [23:0] inv_fx, inv_fy;
  logic [12:0] width_reg;
  logic [24:0] frame_reg;
  logic        reverse, color_on;
  int unsigned column, row, pixel;
  int          mismatches, checked, closed;

  // floor((pos*16 - center) * inv * depth / 2^24), saturated, two's complement
  function automatic logic [32:0] project_axis(input logic [23:0] pos,
                                               input logic [15:0] center,
                                               input logic [23:0] inv,
                                               input logic [15:0] depth);
    logic [28:0] a;
    logic        neg;
    logic [28:0] mag;
    logic [79:0] p;
    logic [79:0] q;
    logic [32:0] v;
    a = {1'b0, pos, 4'b0000};
    neg = 29'(center) > a;
    mag = neg ? 29'(center) - a : a - 29'(center);
    p = 80'(mag) * 80'(inv) * 80'(depth);
    q = p >> 24;
    if (neg && p[23:0] != 24'd0) q = q + 80'd1;
    if (q > 80'(dpd_pkg::XY_LIMIT)) q = 80'(dpd_pkg::XY_LIMIT);
    v = q[32:0];
    return neg ? -v : v;
  endfunction

  always @(posedge clk) begin
    int unsigned w, f;
    logic        last;
    point_t      want, got;
    if (rst) begin
      center_x = '0;
      center_y = '0;
      inv_fx = '0;
      inv_fy = '0;
      width_reg = 13'd640;
      frame_reg = 25'd307200;
      reverse = 1'b0;
      color_on = 1'b1;
      column = 0;
      row = 0;
      pixel = 0;
      mismatches = 0;
      checked = 0;
      closed = 0;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dpd_pkg::REG_CENTER_X: center_x = cfg_data[15:0];
          dpd_pkg::REG_CENTER_Y: center_y = cfg_data[15:0];
          dpd_pkg::REG_INV_FX:   inv_fx = cfg_data[23:0];
          dpd_pkg::REG_INV_FY:   inv_fy = cfg_data[23:0];
          dpd_pkg::REG_WIDTH:    width_reg = cfg_data[12:0];
          dpd_pkg::REG_FRAME:    frame_reg = cfg_data[24:0];
          dpd_pkg::REG_REVERSE:  reverse = cfg_data[0];
          dpd_pkg::REG_COLOR_EN: color_on = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        w = (width_reg == 0) ? 1 :
            ((width_reg > (1 << COLUMN_BITS)) ? (1 << COLUMN_BITS) : width_reg);
        f = (frame_reg == 0) ? 1 :
            ((frame_reg > 25'h1000000) ? 32'h1000000 : frame_reg);
        last = (pixel + 1 >= f);
        want.x = project_axis(24'(column), center_x, inv_fx, s_tdata[15:0]);
        want.y = project_axis(24'(row), center_y, inv_fy, s_tdata[15:0]);
        want.z = s_tdata[15:0];
        if (!color_on) want.color = 24'h000000;
        else if (reverse) want.color = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
        else want.color = s_tdata[39:16];
        want.pad = '0;
        want.last = last;
        expected_points.insert(expected_points.size(), want);
        if (last) begin
          column = 0;
          row = 0;
          pixel = 0;
        end else begin
          pixel = (pixel + 1) & 32'hFFFFFF;
          if (column + 1 >= w) begin
            column = 0;
            row = (row + 1) & 32'hFFFFFF;
          end else begin
            column = (column + 1) & ((1 << COLUMN_BITS) - 1);
          end
        end
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[32:0], m_tdata[65:33], m_tdata[81:66], m_tdata[105:82],
               m_tdata[111:106], m_tlast};
        checked++;
        if (m_tlast) closed++;
        if (expected_points.size() == 0) begin
          if (mismatches < 10)
            $display("point %0d: transaction with no pixel waiting for it", checked);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.color !== want.color || got.pad !== want.pad || got.last !== want.last) begin
            if (mismatches < 10) begin
              $display("point %0d expected: x %0d y %0d z %0d color %06h pad %0h last %0b",
                       checked, $signed(want.x), $signed(want.y), want.z, want.color,
                       want.pad, want.last);
              $display("point %0d actual:   x %0d y %0d z %0d color %06h pad %0h last %0b",
                       checked, $signed(got.x), $signed(got.y), got.z, got.color,
                       got.pad, got.last);
            end
            mismatches++;
          end
        end
      end
    end
    mismatch_count <= mismatches;
    points_in_flight <= expected_points.size();
    points_checked <= checked;
    frames_closed <= closed;
  end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 24;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [24:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic [39:0]  s_tdata = '0;
  logic         m_tready = 1'b0;
  wire logic    s_tready;
  wire logic    m_tvalid;
  wire logic [111:0] m_tdata;
  wire logic    m_tlast;

  int send_gap_pct = 0;
  int stall_pct = 0;
  int pixels_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int mismatch_count, points_in_flight, points_checked, frames_closed;

  depth_pixel_deprojection u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  depth_pixel_deprojection_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .mismatch_count(mismatch_count), .points_in_flight(points_in_flight),
    .points_checked(points_checked), .frames_closed(frames_closed)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [15:0] depth, input logic [7:0] b0,
                            input logic [7:0] b1, input logic [7:0] b2);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b2, b1, b0, depth};
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  task automatic send_random_pixel;
    logic [15:0] depth;
    case ($urandom_range(7))
      0: depth = 16'h0000;
      1: depth = 16'hFFFF;
      default: depth = 16'($urandom_range(16'hFFFF));
    endcase
    send_pixel(depth, 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (points_in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [24:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] cx, input logic [15:0] cy,
                           input logic [23:0] ifx, input logic [23:0] ify,
                           input logic [12:0] width, input logic [24:0] frame,
                           input logic rev, input logic color_en);
    drain();
    write_reg(dpd_pkg::REG_CENTER_X, 25'(cx));
    write_reg(dpd_pkg::REG_CENTER_Y, 25'(cy));
    write_reg(dpd_pkg::REG_INV_FX, 25'(ifx));
    write_reg(dpd_pkg::REG_INV_FY, 25'(ify));
    write_reg(dpd_pkg::REG_WIDTH, 25'(width));
    write_reg(dpd_pkg::REG_FRAME, frame);
    write_reg(dpd_pkg::REG_REVERSE, 25'(rev));
    write_reg(dpd_pkg::REG_COLOR_EN, 25'(color_en));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic int unsigned pick_value(input int unsigned top);
    case ($urandom_range(3))
      0: return 0;
      1: return top;
      default: return $urandom_range(top);
    endcase
  endfunction

  initial begin
    int unsigned phase, i, n;
    logic [12:0] width;
    logic [24:0] frame;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // register defaults after reset
    repeat (6) send_random_pixel();

    configure(16'h0028, 16'h0018, 24'hFFFFFF, 24'h000001, 13'd3, 25'd7, 1'b0, 1'b1);
    send_pixel(16'h0000, 8'h00, 8'h00, 8'h00);
    send_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'h0001, 8'h01, 8'h80, 8'h7F);
    send_pixel(16'hFFFF, 8'hA5, 8'h5A, 8'hC3);
    send_pixel(16'h8000, 8'h3C, 8'hC3, 8'h0F);
    send_pixel(16'h7FFF, 8'hF0, 8'h0F, 8'h55);
    send_pixel(16'hFFFF, 8'hAA, 8'h55, 8'hFF);
    send_pixel(16'h1234, 8'h12, 8'h34, 8'h56);

    // width above column range, frame size zero, reversed colour
    configure(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 13'h1FFF, 25'd0, 1'b1, 1'b1);
    send_pixel(16'hFFFF, 8'h11, 8'h22, 8'h33);
    send_pixel(16'hFFFF, 8'hFF, 8'h00, 8'h80);
    send_pixel(16'h0001, 8'h00, 8'hFF, 8'h01);
    send_pixel(16'h0000, 8'h7F, 8'h80, 8'hFE);

    // width and frame shrink in the middle of a frame, colour off
    configure(16'h0000, 16'h0010, 24'h0AAAAA, 24'h155555, 13'd10, 25'd40, 1'b0, 1'b0);
    repeat (7) send_random_pixel();
    configure(16'h0035, 16'h0000, 24'h155555, 24'h0AAAAA, 13'd4, 25'd5, 1'b1, 1'b0);
    repeat (3) send_random_pixel();

    // one pixel per row so the row counter climbs
    configure(16'($urandom_range(16'hFFFF)), 16'h0000, 24'($urandom_range(24'hFFFFFF)),
              24'hFFFFFF, 13'd0, 25'h1FFFFFF, 1'($urandom_range(1)), 1'b1);
    repeat (200) send_random_pixel();

    for (phase = 0; phase < 16; phase++) begin
      case ($urandom_range(9))
        0: width = 13'd0;
        1: width = 13'd4096;
        2: width = 13'h1FFF;
        3: width = 13'($urandom_range(13'h1FFF));
        default: width = 13'($urandom_range(1, 16));
      endcase
      case ($urandom_range(9))
        0: frame = 25'd0;
        1: frame = 25'h1FFFFFF;
        2: frame = 25'h1000000;
        3: frame = 25'($urandom_range(32'h1FFFFFF));
        default: frame = 25'($urandom_range(1, 64));
      endcase
      configure(16'(pick_value(16'hFFFF)), 16'(pick_value(16'hFFFF)),
                24'(pick_value(24'hFFFFFF)), 24'(pick_value(24'hFFFFFF)),
                width, frame, 1'($urandom_range(1)), 1'($urandom_range(1)));
      case (phase % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 81; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 81; end
        default: begin send_gap_pct = 7; stall_pct = 7; end
      endcase
      n = $urandom_range(50, 80);
      for (i = 0; i < n; i++) begin
        // hold off until the pipeline has emptied
        if ((phase == 5 || phase == 10) && i == n / 2) drain();
        send_random_pixel();
      end
    end

    drain();
    $display("run covered %0d pixels under %0d register settings and four idle patterns",
             pixels_sent, settings_used);
    $display("%0d points compared, %0d of them closing a frame",
             points_checked, frames_closed);
    if (mismatch_count == 0 && points_in_flight == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
